// File: rtl/core/privileged_csr_trap_emulator_macros.svh
// Assertion macros for the privileged CSR trap emulator.
// Used by the top level; no other dependencies.
`ifndef PRIVILEGED_CSR_TRAP_EMULATOR_MACROS_SVH
`define PRIVILEGED_CSR_TRAP_EMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PCTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PCTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PCTE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PCTE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/pcte_pkg.sv
// Shared types and constants for the privileged CSR trap emulator.
// No dependencies.
`default_nettype none
package pcte_pkg;
  localparam logic [1:0] MODE_U = 2'd0;
  localparam logic [1:0] MODE_S = 2'd1;
  localparam logic [1:0] MODE_M = 2'd2;

  localparam int NAMED_COUNT = 33;
  localparam logic [63:0] VENDOR_ID = 64'h0000_6373_6535_3336;
  localparam logic [11:0] PMP_ADDR_BASE = 12'h3B0;
  localparam logic [11:0] PMP_CFG_BASE = 12'h3A0;
  localparam logic [11:0] CSR_ECALL = 12'h000;
  localparam logic [11:0] CSR_SRET = 12'h102;
  localparam logic [11:0] CSR_MRET = 12'h302;
  localparam logic [11:0] CSR_MVENDOR = 12'hF11;

  localparam logic [2:0] F3_SYS = 3'd0;
  localparam logic [2:0] F3_CSRW = 3'd1;
  localparam logic [2:0] F3_CSRR = 3'd2;

  localparam logic [5:0] IDX_SSTATUS = 6'd8;
  localparam logic [5:0] IDX_STVEC = 6'd10;
  localparam logic [5:0] IDX_SEPC = 6'd12;
  localparam logic [5:0] IDX_MVENDOR = 6'd14;
  localparam logic [5:0] IDX_MSTATUS = 6'd19;
  localparam logic [5:0] IDX_MTVEC = 6'd24;
  localparam logic [5:0] IDX_MEPC = 6'd27;

  typedef logic [11:0] csr_code_t;
  typedef csr_code_t [NAMED_COUNT-1:0] csr_table_t;
  localparam csr_table_t CSR_CODES = '{
    12'h34B, 12'h34A, 12'h344, 12'h343, 12'h342, 12'h341, 12'h340,
    12'h306, 12'h305, 12'h304, 12'h303, 12'h302, 12'h301, 12'h300,
    12'hF15, 12'hF14, 12'hF13, 12'hF12, 12'hF11,
    12'h180, 12'h141, 12'h106, 12'h105, 12'h104, 12'h100,
    12'h044, 12'h043, 12'h042, 12'h040, 12'h041, 12'h005, 12'h004, 12'h000};

  typedef enum logic [1:0] {
    ST_IDLE, ST_EXEC, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_ECALL, OP_SRET, OP_MRET, OP_CSRW, OP_CSRR, OP_BAD
  } op_t;

  // Which storage a CSR lives in.
  typedef enum logic [1:0] {
    LOC_NONE, LOC_NAMED, LOC_PADDR, LOC_PCFG
  } loc_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic busy;
  } ctl_stat_t;

  function automatic logic [1:0] csr_level(input logic [11:0] csr);
    logic [3:0] top;
    top = csr[11:8];
    if (top == 4'd0) return MODE_U;
    if (top == 4'd1) return MODE_S;
    return MODE_M;
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/pcte_stream_if.sv
// Valid/ready channel carrying input and result words.
// Depends on nothing.
`default_nettype none
interface pcte_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  logic [63:0] pc;
  logic [63:0] source_value;
  modport source (output valid, instruction, pc, source_value, input ready);
  modport sink (input valid, instruction, pc, source_value, output ready);
endinterface

interface pcte_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] next_pc;
  logic        kill;
  logic        reg_write;
  logic [4:0]  dest_reg;
  logic [63:0] dest_value;
  logic [1:0]  mode_out;
  logic        pmp_switch;
  modport source (output valid, next_pc, kill, reg_write, dest_reg, dest_value,
                  mode_out, pmp_switch, input ready);
  modport sink (input valid, next_pc, kill, reg_write, dest_reg, dest_value,
                mode_out, pmp_switch, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pcte_ctrl.sv
// Controller: sequences load, execute and result hand-off for one word.
// Depends on pcte_pkg.
`default_nettype none
module pcte_ctrl import pcte_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output ctl_cmd_t  cmd
);
  state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_DONE;
      ST_DONE: if (out_ready) state_nxt = in_valid ? ST_EXEC : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: a new word is taken when idle or as the result leaves.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: cmd.exec = 1'b1;
      ST_DONE: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: ;
    endcase
    cmd.load = in_valid & in_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// File: rtl/core/pcte_datapath.sv
// Datapath: CSR storage, decode, privilege checks and result register.
// Depends on pcte_pkg.
`default_nettype none
module pcte_datapath import pcte_pkg::*; #(
  parameter int PMP_ADDR_COUNT = 64,
  parameter int PMP_CFG_COUNT  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire ctl_cmd_t    cmd,
  input  wire logic [31:0] in_instruction,
  input  wire logic [63:0] in_pc,
  input  wire logic [63:0] in_source_value,
  output logic [63:0]      out_next_pc,
  output logic             out_kill,
  output logic             out_reg_write,
  output logic [4:0]       out_dest_reg,
  output logic [63:0]      out_dest_value,
  output logic [1:0]       out_mode_out,
  output logic             out_pmp_switch
);
  localparam int AW = (PMP_ADDR_COUNT > 1) ? $clog2(PMP_ADDR_COUNT) : 1;
  localparam int CW = (PMP_CFG_COUNT > 1) ? $clog2(PMP_CFG_COUNT) : 1;

  // State.
  logic [1:0]                mode_r;
  logic                      pmpw_r;
  logic [63:0]               named_r [NAMED_COUNT];
  logic [63:0]               paddr_mem [PMP_ADDR_COUNT];
  logic [PMP_ADDR_COUNT-1:0] paddr_vld_r;
  logic [63:0]               pcfg_r  [PMP_CFG_COUNT];

  // CSR lookup on the incoming word; the outcome is registered at load.
  logic [11:0] in_csr, in_aoff, in_coff;
  loc_t        in_loc;
  logic [5:0]  in_nidx;
  assign in_csr  = in_instruction[31:20];
  assign in_aoff = in_csr - PMP_ADDR_BASE;
  assign in_coff = in_csr - PMP_CFG_BASE;
  always_comb begin
    in_loc  = LOC_NONE;
    in_nidx = '0;
    for (int i = 0; i < NAMED_COUNT; i++) begin
      if (CSR_CODES[i] == in_csr) begin
        in_loc  = LOC_NAMED;
        in_nidx = 6'(i);
      end
    end
    if (in_loc == LOC_NONE) begin
      if (in_csr >= PMP_ADDR_BASE && 32'(in_aoff) < 32'(PMP_ADDR_COUNT))
        in_loc = LOC_PADDR;
      else if (in_csr >= PMP_CFG_BASE && 32'(in_coff) < 32'(PMP_CFG_COUNT))
        in_loc = LOC_PCFG;
    end
  end

  // Input word register, with the lookup and the read of the selected CSR.
  logic [31:0]   instr_r;
  logic [63:0]   pc_r, src_r;
  loc_t          loc_r;
  logic [5:0]    nidx_r;
  logic [AW-1:0] aidx_r;
  logic [CW-1:0] cidx_r;
  logic [63:0]   other_q;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      instr_r <= in_instruction;
      pc_r    <= in_pc;
      src_r   <= in_source_value;
      loc_r   <= in_loc;
      nidx_r  <= in_nidx;
      aidx_r  <= in_aoff[AW-1:0];
      cidx_r  <= in_coff[CW-1:0];
      unique case (in_loc)
        LOC_NAMED: other_q <= named_r[in_nidx];
        LOC_PCFG:  other_q <= pcfg_r[in_coff[CW-1:0]];
        default:   other_q <= '0;
      endcase
    end
  end

  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [11:0] csr;
  assign rd  = instr_r[11:7];
  assign f3  = instr_r[14:12];
  assign csr = instr_r[31:20];

  // Decode.
  op_t op;
  always_comb begin
    if (f3 == F3_SYS && csr == CSR_ECALL) op = OP_ECALL;
    else if (f3 == F3_SYS && csr == CSR_SRET) op = OP_SRET;
    else if (f3 == F3_SYS && csr == CSR_MRET) op = OP_MRET;
    else if (f3 == F3_CSRW) op = OP_CSRW;
    else if (f3 == F3_CSRR) op = OP_CSRR;
    else op = OP_BAD;
  end

  logic        priv_ok;
  assign priv_ok = mode_r >= csr_level(csr);

  // Execute.
  logic [63:0] npc;
  logic        kill, wr, sw, csr_we, epc_we, pmpw_set;
  logic [1:0]  mode_nxt;
  logic [5:0]  epc_idx;
  logic [1:0]  mpp;
  always_comb begin
    npc = pc_r; kill = 1'b0; wr = 1'b0; sw = 1'b0; csr_we = 1'b0;
    epc_we = 1'b0; epc_idx = IDX_SEPC; pmpw_set = 1'b0; mode_nxt = mode_r;
    mpp = named_r[IDX_MSTATUS][12:11];
    unique case (op)
      OP_ECALL: begin
        if (mode_r == MODE_U) begin
          mode_nxt = MODE_S; epc_we = 1'b1; epc_idx = IDX_SEPC;
          npc = named_r[IDX_STVEC];
        end else if (mode_r == MODE_S) begin
          mode_nxt = MODE_M; epc_we = 1'b1; epc_idx = IDX_MEPC;
          npc = named_r[IDX_MTVEC];
        end
      end
      OP_SRET: begin
        if (mode_r == MODE_U) kill = 1'b1;
        else if (named_r[IDX_SSTATUS][8]) begin
          mode_nxt = MODE_S; npc = named_r[IDX_SEPC];
        end else if (mode_r == MODE_S) begin
          mode_nxt = MODE_U; npc = named_r[IDX_SEPC];
        end else kill = 1'b1;
      end
      OP_MRET: begin
        if (mpp == 2'd2) kill = 1'b1;
        else begin
          mode_nxt = (mpp == 2'd3) ? MODE_M : mpp;
          npc = named_r[IDX_MEPC];
          sw = pmpw_r && (mode_nxt != MODE_M);
        end
      end
      OP_CSRW: begin
        npc = pc_r + 64'd4;
        if (loc_r == LOC_NONE) kill = 1'b1;
        else begin
          if (csr == CSR_MVENDOR && src_r == '0) kill = 1'b1;
          if (loc_r != LOC_NAMED) pmpw_set = 1'b1;
          if (priv_ok) csr_we = 1'b1;
          else kill = 1'b1;
        end
      end
      OP_CSRR: begin
        npc = pc_r + 64'd4;
        if (loc_r == LOC_NONE) kill = 1'b1;
        else if (priv_ok && rd != '0) wr = 1'b1;
      end
      default: kill = 1'b1;
    endcase
  end

  // PMP address memory: read as a word is loaded, written on execute.
  // An entry reads as zero until its valid bit is set by a write.
  logic [63:0] paddr_q;
  logic        paddr_vld_q;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      paddr_q     <= paddr_mem[in_aoff[AW-1:0]];
      paddr_vld_q <= paddr_vld_r[in_aoff[AW-1:0]];
    end
    if (cmd.exec && csr_we && loc_r == LOC_PADDR) paddr_mem[aidx_r] <= src_r;
  end

  logic [63:0] rdata;
  always_comb begin
    if (loc_r == LOC_PADDR) rdata = paddr_vld_q ? paddr_q : '0;
    else rdata = other_q;
  end

  // State update on execute.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_M;
      pmpw_r      <= 1'b0;
      paddr_vld_r <= '0;
      for (int i = 0; i < NAMED_COUNT; i++)
        named_r[i] <= (6'(i) == IDX_MVENDOR) ? VENDOR_ID : '0;
      for (int i = 0; i < PMP_CFG_COUNT; i++) pcfg_r[i] <= '0;
    end else if (cmd.exec) begin
      mode_r <= mode_nxt;
      if (pmpw_set) pmpw_r <= 1'b1;
      if (epc_we) named_r[epc_idx] <= pc_r;
      if (csr_we) begin
        unique case (loc_r)
          LOC_NAMED: named_r[nidx_r] <= src_r;
          LOC_PADDR: paddr_vld_r[aidx_r] <= 1'b1;
          LOC_PCFG:  pcfg_r[cidx_r] <= src_r;
          default: ;
        endcase
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_next_pc    <= npc;
      out_kill       <= kill;
      out_reg_write  <= wr;
      out_dest_reg   <= wr ? rd : '0;
      out_dest_value <= wr ? rdata : '0;
      out_mode_out   <= mode_nxt;
      out_pmp_switch <= sw;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/privileged_csr_trap_emulator.sv
// An accepted word is executed in the EXEC state; its result is registered
// in the result register and offered in the DONE state. No new word is taken
// during execute; the next word is taken as a result leaves, and a stall holds it.
// Reset (synchronous, rst_n low) sets machine mode, clears all CSRs except
// mvendorid, and clears the PMP-written flag; PMP address entries read as
// zero until written, tracked by one valid bit each, so no clearing pass.
`default_nettype none
`include "privileged_csr_trap_emulator_macros.svh"
module privileged_csr_trap_emulator import pcte_pkg::*; #(
  parameter int PMP_ADDR_COUNT = 64,
  parameter int PMP_CFG_COUNT  = 8
) (
  input wire logic clk,
  input wire logic rst_n,
  pcte_in_if.sink    in_ch,
  pcte_out_if.source out_ch
);
  ctl_cmd_t cmd;

  pcte_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd
  );

  pcte_datapath #(.PMP_ADDR_COUNT(PMP_ADDR_COUNT), .PMP_CFG_COUNT(PMP_CFG_COUNT)) u_dp (
    .clk, .rst_n, .cmd,
    .in_instruction(in_ch.instruction), .in_pc(in_ch.pc),
    .in_source_value(in_ch.source_value),
    .out_next_pc(out_ch.next_pc), .out_kill(out_ch.kill),
    .out_reg_write(out_ch.reg_write), .out_dest_reg(out_ch.dest_reg),
    .out_dest_value(out_ch.dest_value), .out_mode_out(out_ch.mode_out),
    .out_pmp_switch(out_ch.pmp_switch)
  );

  // A loaded word is executed in the next cycle.
  `PCTE_ASSERT_NEXT(a_load_result, clk, rst_n, cmd.load, cmd.exec)
  `PCTE_ASSERT_IMPL(a_no_load_exec, clk, rst_n, cmd.exec, !cmd.load)
  `PCTE_ASSERT_IMPL(a_sw_nokill, clk, rst_n, out_ch.valid && out_ch.pmp_switch,
                    !out_ch.kill && out_ch.mode_out != MODE_M)
endmodule
`default_nettype wire
